// ----- design/assert_macros.svh -----
// Assertion macros used by the spot light top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define SPL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SPL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/spl_pkg.sv -----
// Package: widths, stage map, register codes and word types of the spot light block.
`default_nettype none
package spl_pkg;

   localparam int COORD_BITS = 20;
   localparam int DIR_BITS   = 16;
   localparam int DIR_FRAC   = 14;
   localparam int COLOR_W    = 16;
   localparam int OUT_W      = 32;
   localparam int DIST_W     = 21;
   localparam int CSR_W      = 3 * COORD_BITS;

   localparam int ONE_Q14    = 1 << DIR_FRAC;
   localparam int HALF_Q14   = ONE_Q14 / 2;
   localparam int THREE_Q14  = 3 * ONE_Q14;

   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int MAG_W   = COORD_BITS;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int DSQ_W   = SQ_W + 2;
   localparam int ROOT_W  = DSQ_W / 2;
   localparam int DNUM_W  = MAG_W + DIR_FRAC + 2;
   localparam int DQ_W    = DIR_FRAC + 1;
   localparam int PROD_W  = 2 * DIR_BITS;
   localparam int SUM_W   = PROD_W + 2;
   localparam int COS_W   = 20;
   localparam int SPAN_W  = 24;
   localparam int TP_W    = COS_W + SPAN_W;
   localparam int TR_W    = TP_W - DIR_FRAC;
   localparam int TT_W    = 2 * DQ_W;
   localparam int W_W     = DIR_FRAC + 2;
   localparam int TV_W    = DQ_W + W_W;
   localparam int V_W     = DIR_FRAC + 2;
   localparam int CP_W    = 32;
   localparam int CR_W    = CP_W + DIR_FRAC;
   localparam int CW      = DSQ_W + OUT_W + 1;

   // stage map
   localparam int ST_SQR    = 0;
   localparam int ST_SUM    = 1;
   localparam int ST_SQ     = 2;
   localparam int ST_DINIT  = ST_SQ + ROOT_W;
   localparam int ST_DV     = ST_DINIT + 1;
   localparam int ST_DIR    = ST_DV + DQ_W;
   localparam int ST_PROD   = ST_DIR + 1;
   localparam int ST_COS    = ST_PROD + 1;
   localparam int ST_TEST   = ST_COS + 1;
   localparam int ST_T      = ST_TEST + 1;
   localparam int ST_TT     = ST_T + 1;
   localparam int ST_T2     = ST_TT + 1;
   localparam int ST_TV     = ST_T2 + 1;
   localparam int ST_V      = ST_TV + 1;
   localparam int ST_CP     = ST_V + 1;
   localparam int ST_CINIT  = ST_CP + 1;
   localparam int ST_CD     = ST_CINIT + 1;
   localparam int NS        = ST_CD + OUT_W + 1;

   typedef enum logic [2:0] {
      REG_LIGHT_POSITION = 3'd0,
      REG_SPOT_AXIS      = 3'd1,
      REG_LIGHT_COLOR    = 3'd2,
      REG_OUTER_COSINE   = 3'd3,
      REG_INNER_COSINE   = 3'd4,
      REG_INV_SPAN       = 3'd5,
      REG_PHOTON_ONLY    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                          ok;
      logic                          full;
      logic [2:0][DIFF_W-1:0]        d;
      logic [2:0][SQ_W-1:0]          sq;
      logic [DSQ_W-1:0]              dsq;
      logic [DSQ_W-1:0]              srem;
      logic [DSQ_W-1:0]              root;
      logic [ROOT_W-1:0]             dlen;
      logic [2:0][DNUM_W-1:0]        drem;
      logic [2:0][DQ_W-1:0]          dq;
      logic [2:0][DIR_BITS-1:0]      dir;
      logic [2:0][PROD_W-1:0]        prod;
      logic [COS_W-1:0]              cosv;
      logic [TP_W-1:0]               tprod;
      logic [DQ_W-1:0]               t;
      logic [TT_W-1:0]               tt;
      logic [DQ_W-1:0]               t2;
      logic [TV_W-1:0]               tv;
      logic [V_W-1:0]                v;
      logic [2:0][CP_W-1:0]          cprod;
      logic [2:0][CR_W-1:0]          crem;
      logic [2:0][OUT_W-1:0]         cq;
      logic [2:0]                    sat;
      logic [OUT_W-1:0]              time_tag;
   } item_type;

   typedef struct packed {
      logic                 lit;
      logic [DIR_BITS-1:0]  dir_x;
      logic [DIR_BITS-1:0]  dir_y;
      logic [DIR_BITS-1:0]  dir_z;
      logic [DIST_W-1:0]    distance;
      logic [OUT_W-1:0]     red_out;
      logic [OUT_W-1:0]     green_out;
      logic [OUT_W-1:0]     blue_out;
      logic [OUT_W-1:0]     time_out;
   } rsp_word_type;

endpackage
`default_nettype wire

// ----- design/spl_channels.sv -----
// Interfaces: query word channel and result word channel.
`default_nettype none
interface spl_req_if import spl_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] surface_x;
   logic signed [COORD_BITS-1:0] surface_y;
   logic signed [COORD_BITS-1:0] surface_z;
   logic [OUT_W-1:0]             time_tag;
   modport source(output valid, surface_x, surface_y, surface_z, time_tag, input ready);
   modport sink(input valid, surface_x, surface_y, surface_z, time_tag, output ready);
endinterface

interface spl_rsp_if import spl_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       lit;
   logic signed [DIR_BITS-1:0] dir_x;
   logic signed [DIR_BITS-1:0] dir_y;
   logic signed [DIR_BITS-1:0] dir_z;
   logic [DIST_W-1:0]          distance;
   logic [OUT_W-1:0]           red_out;
   logic [OUT_W-1:0]           green_out;
   logic [OUT_W-1:0]           blue_out;
   logic [OUT_W-1:0]           time_out;
   modport source(output valid, lit, dir_x, dir_y, dir_z, distance, red_out, green_out,
                  blue_out, time_out, input ready);
   modport sink(input valid, lit, dir_x, dir_y, dir_z, distance, red_out, green_out,
                blue_out, time_out, output ready);
endinterface
`default_nettype wire

// ----- design/spot_light_attenuation.sv -----
// Top level: spot light illumination query pipeline with smoothstep cone falloff.
// A result word is offered from the output buffer after its query word has passed every pipeline stage.
// Throughput: one word per cycle while not stalled; sqrt, direction and color dividers are fully pipelined.
// A 2-word output buffer holds finished words; the pipeline stalls only when it is full.
// Reset (synchronous): registers return to defaults (inner cosine and span 1.0, others 0),
// pipeline and output buffer empty.
`default_nettype none
`include "assert_macros.svh"
module spot_light_attenuation import spl_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   spl_req_if.sink                   req_ch,
   spl_rsp_if.source                 rsp_ch,
   input  wire logic                 csr_we,
   input  wire logic [2:0]           csr_index,
   input  wire logic [CSR_W-1:0]     csr_data
);

   logic [CSR_W-1:0]          light_position_ff;
   logic [3*DIR_BITS-1:0]     spot_axis_ff;
   logic [3*COLOR_W-1:0]      light_color_ff;
   logic signed [15:0]        outer_cosine_ff;
   logic signed [15:0]        inner_cosine_ff;
   logic [SPAN_W-1:0]         inverse_cosine_span_ff;
   logic                      photon_only_ff;

   item_type                  pipe_ff [NS];
   item_type                  nxt [NS-1];
   item_type                  stg0;
   logic [NS-1:0]             valid_ff;

   rsp_word_type              fifo_ff [2];
   rsp_word_type              fin_word;
   logic                      wr_ptr_ff, rd_ptr_ff;
   logic [1:0]                cnt_ff, cnt_in;

   logic en, accept, push, pop;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         light_position_ff      <= '0;
         spot_axis_ff           <= '0;
         light_color_ff         <= '0;
         outer_cosine_ff        <= '0;
         inner_cosine_ff        <= 16'(ONE_Q14);
         inverse_cosine_span_ff <= SPAN_W'(ONE_Q14);
         photon_only_ff         <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_LIGHT_POSITION: light_position_ff      <= csr_data;
            REG_SPOT_AXIS:      spot_axis_ff           <= csr_data[3*DIR_BITS-1:0];
            REG_LIGHT_COLOR:    light_color_ff         <= csr_data[3*COLOR_W-1:0];
            REG_OUTER_COSINE:   outer_cosine_ff        <= csr_data[15:0];
            REG_INNER_COSINE:   inner_cosine_ff        <= csr_data[15:0];
            REG_INV_SPAN:       inverse_cosine_span_ff <= csr_data[SPAN_W-1:0];
            REG_PHOTON_ONLY:    photon_only_ff         <= csr_data[0];
            default: ;
         endcase
      end
   end

   function automatic logic [DIFF_W-1:0] abs_d(input logic [DIFF_W-1:0] x);
      return x[DIFF_W-1] ? DIFF_W'(-$signed(x)) : x;
   endfunction

   function automatic item_type step(input int k, input item_type a);
      item_type                r;
      logic [DIFF_W-1:0]       mag;
      logic signed [SUM_W-1:0] s;
      logic [DSQ_W:0]          trial;
      logic [DSQ_W-1:0]        bitv;
      logic [DSQ_W-1:0]        sum;
      logic [DNUM_W-1:0]       dden;
      logic [CW-1:0]           cden;
      logic signed [COS_W:0]   df;
      logic [TR_W-1:0]         tr;
      logic [DQ_W-1:0]         qc;
      logic [DIR_BITS-1:0]     mq;
      logic [W_W-1:0]          w;
      int                      sh;
      r = a;
      if (k == ST_SQR) begin
         for (int i = 0; i < 3; i++) begin
            mag = abs_d(a.d[i]);
            r.sq[i] = SQ_W'(mag[MAG_W-1:0]) * SQ_W'(mag[MAG_W-1:0]);
         end
      end else if (k == ST_SUM) begin
         sum = DSQ_W'(a.sq[0]) + DSQ_W'(a.sq[1]) + DSQ_W'(a.sq[2]);
         r.dsq  = sum;
         r.srem = sum;
         r.root = '0;
         if (sum == '0) r.ok = 1'b0;
      end else if (k >= ST_SQ && k < ST_DINIT) begin
         sh    = 2 * (ST_DINIT - 1 - k);
         bitv  = DSQ_W'(1) << sh;
         trial = {1'b0, a.root} + {1'b0, bitv};
         if ({1'b0, a.srem} >= trial) begin
            r.srem = a.srem - trial[DSQ_W-1:0];
            r.root = (a.root >> 1) + bitv;
         end else begin
            r.root = a.root >> 1;
         end
      end else if (k == ST_DINIT) begin
         r.dlen = a.root[ROOT_W-1:0];
         for (int i = 0; i < 3; i++) begin
            mag = abs_d(a.d[i]);
            r.drem[i] = (DNUM_W'(mag[MAG_W-1:0]) << DIR_FRAC) + DNUM_W'(r.dlen >> 1);
            r.dq[i] = '0;
         end
      end else if (k >= ST_DV && k < ST_DIR) begin
         sh = ST_DIR - 1 - k;
         dden = DNUM_W'(a.dlen) << sh;
         for (int i = 0; i < 3; i++) begin
            if (a.drem[i] >= dden) begin
               r.drem[i] = a.drem[i] - dden;
               r.dq[i][sh] = 1'b1;
            end
         end
      end else if (k == ST_DIR) begin
         for (int i = 0; i < 3; i++) begin
            qc = (a.dq[i] > DQ_W'(ONE_Q14)) ? DQ_W'(ONE_Q14) : a.dq[i];
            mq = DIR_BITS'(qc);
            r.dir[i] = a.d[i][DIFF_W-1] ? DIR_BITS'(~mq + 1'b1) : mq;
         end
      end else if (k == ST_PROD) begin
         for (int i = 0; i < 3; i++)
            r.prod[i] = $signed(spot_axis_ff[DIR_BITS*i +: DIR_BITS]) * $signed(a.dir[i]);
      end else if (k == ST_COS) begin
         s = SUM_W'($signed(a.prod[0])) + SUM_W'($signed(a.prod[1]))
           + SUM_W'($signed(a.prod[2]));
         r.cosv = COS_W'(s >>> DIR_FRAC);
      end else if (k == ST_TEST) begin
         if ($signed(a.cosv) < outer_cosine_ff) r.ok = 1'b0;
         r.full  = ($signed(a.cosv) >= inner_cosine_ff);
         df      = $signed(a.cosv) - outer_cosine_ff;
         r.tprod = TP_W'(df[COS_W-1:0]) * TP_W'(inverse_cosine_span_ff);
      end else if (k == ST_T) begin
         tr  = TR_W'((a.tprod + TP_W'(HALF_Q14)) >> DIR_FRAC);
         r.t = (tr > TR_W'(ONE_Q14)) ? DQ_W'(ONE_Q14) : tr[DQ_W-1:0];
      end else if (k == ST_TT) begin
         r.tt = TT_W'(a.t) * TT_W'(a.t);
      end else if (k == ST_T2) begin
         r.t2 = DQ_W'((a.tt + TT_W'(HALF_Q14)) >> DIR_FRAC);
      end else if (k == ST_TV) begin
         w    = W_W'(THREE_Q14) - {a.t, 1'b0};
         r.tv = TV_W'(a.t2) * TV_W'(w);
      end else if (k == ST_V) begin
         r.v = a.full ? V_W'(ONE_Q14) : V_W'((a.tv + TV_W'(HALF_Q14)) >> DIR_FRAC);
      end else if (k == ST_CP) begin
         for (int i = 0; i < 3; i++)
            r.cprod[i] = CP_W'(light_color_ff[COLOR_W*i +: COLOR_W]) * CP_W'(a.v);
      end else if (k == ST_CINIT) begin
         for (int i = 0; i < 3; i++) begin
            r.crem[i] = CR_W'(a.cprod[i]) << DIR_FRAC;
            r.sat[i]  = (CW'(r.crem[i]) >= (CW'(a.dsq) << OUT_W));
            r.cq[i]   = '0;
         end
      end else begin
         sh = NS - 2 - k;
         cden = CW'(a.dsq) << sh;
         for (int i = 0; i < 3; i++) begin
            if (CW'(a.crem[i]) >= cden) begin
               r.crem[i] = a.crem[i] - cden[CR_W-1:0];
               r.cq[i][sh] = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // query word into stage 0
   always_comb begin
      stg0          = '0;
      stg0.ok       = !photon_only_ff;
      stg0.d[0]     = DIFF_W'($signed(light_position_ff[0 +: COORD_BITS]))
                    - DIFF_W'(req_ch.surface_x);
      stg0.d[1]     = DIFF_W'($signed(light_position_ff[COORD_BITS +: COORD_BITS]))
                    - DIFF_W'(req_ch.surface_y);
      stg0.d[2]     = DIFF_W'($signed(light_position_ff[2*COORD_BITS +: COORD_BITS]))
                    - DIFF_W'(req_ch.surface_z);
      stg0.time_tag = req_ch.time_tag;
   end

   always_comb begin
      for (int k = 0; k < NS - 1; k++) nxt[k] = step(k, pipe_ff[k]);
   end

   assign en     = (cnt_ff != 2'd2);
   assign accept = req_ch.valid && en;
   assign req_ch.ready = en;
   assign push   = en && valid_ff[NS-1];
   assign pop    = rsp_ch.valid && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (en) valid_ff <= {valid_ff[NS-2:0], accept};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= stg0;
         for (int k = 0; k < NS - 1; k++) pipe_ff[k+1] <= nxt[k];
      end
   end

   // final word, zeroed when unlit
   always_comb begin
      fin_word = '0;
      if (pipe_ff[NS-1].ok) begin
         fin_word.lit       = 1'b1;
         fin_word.dir_x     = pipe_ff[NS-1].dir[0];
         fin_word.dir_y     = pipe_ff[NS-1].dir[1];
         fin_word.dir_z     = pipe_ff[NS-1].dir[2];
         fin_word.distance  = DIST_W'(pipe_ff[NS-1].dlen);
         fin_word.red_out   = pipe_ff[NS-1].sat[0] ? '1 : pipe_ff[NS-1].cq[0];
         fin_word.green_out = pipe_ff[NS-1].sat[1] ? '1 : pipe_ff[NS-1].cq[1];
         fin_word.blue_out  = pipe_ff[NS-1].sat[2] ? '1 : pipe_ff[NS-1].cq[2];
         fin_word.time_out  = pipe_ff[NS-1].time_tag;
      end
   end

   // output buffer
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) fifo_ff[wr_ptr_ff] <= fin_word;
   end

   assign rsp_ch.valid     = (cnt_ff != 2'd0);
   assign rsp_ch.lit       = fifo_ff[rd_ptr_ff].lit;
   assign rsp_ch.dir_x     = fifo_ff[rd_ptr_ff].dir_x;
   assign rsp_ch.dir_y     = fifo_ff[rd_ptr_ff].dir_y;
   assign rsp_ch.dir_z     = fifo_ff[rd_ptr_ff].dir_z;
   assign rsp_ch.distance  = fifo_ff[rd_ptr_ff].distance;
   assign rsp_ch.red_out   = fifo_ff[rd_ptr_ff].red_out;
   assign rsp_ch.green_out = fifo_ff[rd_ptr_ff].green_out;
   assign rsp_ch.blue_out  = fifo_ff[rd_ptr_ff].blue_out;
   assign rsp_ch.time_out  = fifo_ff[rd_ptr_ff].time_out;

   `SPL_ASSERT_ALWAYS(a_buf_bound, clock, reset || cnt_ff != 2'd3, "output buffer count overflow")
   `SPL_ASSERT(a_accept_enters, clock, reset, accept |=> valid_ff[0], "accepted word lost")
   `SPL_ASSERT(a_stall_holds, clock, reset, !en |=> $stable(valid_ff), "pipeline moved in stall")
   `SPL_ASSERT(a_unlit_zero, clock, reset,
      (rsp_ch.valid && !rsp_ch.lit) |-> (rsp_ch.red_out == '0 && rsp_ch.time_out == '0),
      "unlit word carries data")

endmodule
`default_nettype wire
